[sv/abm_pkg.sv]
`timescale 1ns / 1ps
// shared constants and codes for the adjacency bit matrix unit
package abm_pkg;

    // built maximum vertex count
    localparam int DEFAULT_MAX_VERTICES = 64;

    // fixed port widths
    localparam int VERTEX_W = 6;
    localparam int VCOUNT_W = 7;
    localparam int COUNT_W  = 13;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 1;

    // saturation limit of the edge counter
    localparam logic [COUNT_W-1:0] EDGE_TOTAL_MAX = 13'd8191;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTED     = 1'd1;

    // reset value of the vertex count register
    localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

endpackage

[sv/adjacency_bit_matrix_unit.sv]
`timescale 1ns / 1ps
// adjacency bit matrix unit: row memory, edge counter and command sequencer
// A command is taken in the idle state, which reads its row. The result is loaded from
// the read state for query, failed commands and directed (or self-loop) insert/remove,
// and from the mirror state (second row rewrite) for undirected insert/remove; next
// neighbor scans 8-column groups in turn, at most ceil(MAX_VERTICES/8). One item at a
// time, and a stalled result holds it. Reset clears per-row valid flags at once (no
// clearing pass) and the edge count, and sets the config registers to their defaults.
module adjacency_bit_matrix_unit #(
    parameter int MAX_VERTICES = abm_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [abm_pkg::CMD_W-1:0]      command,
    input  logic [abm_pkg::VERTEX_W-1:0]   from_vertex,
    input  logic [abm_pkg::VERTEX_W-1:0]   to_vertex,
    input  logic [abm_pkg::VERTEX_W-1:0]   search_start,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           status,
    output logic                           edge_present,
    output logic [abm_pkg::VCOUNT_W-1:0]   neighbor,
    output logic [abm_pkg::COUNT_W-1:0]    edge_count,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [abm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abm_pkg::VCOUNT_W-1:0]   cfg_data
);

    localparam int A_W    = $clog2(MAX_VERTICES);
    localparam int N_RAW  = $clog2(MAX_VERTICES + 1);
    localparam int N_W    = (N_RAW > abm_pkg::VCOUNT_W) ? N_RAW : abm_pkg::VCOUNT_W;
    localparam int GROUPS = (MAX_VERTICES + 7) / 8;
    localparam int G_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD_W  = GROUPS * 8;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_MIRROR = 2'd2;
    localparam logic [1:0] ST_SCAN   = 2'd3;

    // row memory
    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] mem_q;
    logic                    mem_re;
    logic                    mem_we;
    logic [A_W-1:0]          mem_raddr;
    logic [A_W-1:0]          mem_waddr;
    logic [MAX_VERTICES-1:0] mem_wdata;

    // control and payload registers
    logic [1:0]                      state_reg, state_next;
    logic [MAX_VERTICES-1:0]         row_valid_reg;
    logic                            rd_valid_reg;
    logic [abm_pkg::VCOUNT_W-1:0]    vertex_count_reg;
    logic                            directed_reg;
    logic [abm_pkg::COUNT_W-1:0]     edge_total_reg, edge_total_next;
    logic [abm_pkg::CMD_W-1:0]       cmd_reg;
    logic [abm_pkg::VERTEX_W-1:0]    from_reg;
    logic [abm_pkg::VERTEX_W-1:0]    to_reg;
    logic [abm_pkg::VERTEX_W-1:0]    start_reg;
    logic                            bad_reg;
    logic [PAD_W-1:0]                scan_reg, scan_next;
    logic [G_W-1:0]                  grp_reg, grp_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            status_reg, status_next;
    logic                            present_reg, present_next;
    logic [abm_pkg::VCOUNT_W-1:0]    neighbor_reg, neighbor_next;
    logic [abm_pkg::COUNT_W-1:0]     count_out_reg, count_out_next;

    // combinational helpers
    logic                            in_accept;
    logic                            out_free;
    logic                            out_load;
    logic [N_W-1:0]                  n_eff;
    logic                            bad_now;
    logic [MAX_VERTICES-1:0]         row_data;
    logic [A_W-1:0]                  from_addr;
    logic [A_W-1:0]                  to_addr;
    logic                            cur_bit;
    logic                            need_mirror;
    logic                            start_ok;
    logic [PAD_W-1:0]                search_mask;
    logic [7:0]                      grp_bits;
    logic [2:0]                      grp_first;
    logic                            grp_hit;
    logic                            grp_last;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign edge_present = present_reg;
    assign neighbor     = neighbor_reg;
    assign edge_count   = count_out_reg;

    // effective vertex count, limited to the built maximum
    always_comb
    begin
        if (N_W'(vertex_count_reg) > N_W'(MAX_VERTICES))
            n_eff = N_W'(MAX_VERTICES);
        else
            n_eff = N_W'(vertex_count_reg);
    end

    // range check on the incoming beat
    assign bad_now = (N_W'(from_vertex) >= n_eff) ||
                     ((command != abm_pkg::CMD_NEXT) && (N_W'(to_vertex) >= n_eff));

    // row as seen by the logic: never-written rows read as clear
    assign row_data    = rd_valid_reg ? mem_q : '0;
    assign from_addr   = A_W'(from_reg);
    assign to_addr     = A_W'(to_reg);
    assign cur_bit     = row_data[to_addr];
    assign need_mirror = !directed_reg && (from_reg != to_reg);
    assign start_ok    = (N_W'(start_reg) < n_eff);

    // columns at or after the start and below the vertex count
    always_comb
    begin
        for (int c = 0; c < PAD_W; c++)
        begin
            search_mask[c] = (N_W'(c) >= N_W'(start_reg)) && (N_W'(c) < n_eff);
        end
    end

    // first set bit in the current 8-column group
    assign grp_bits = scan_reg[grp_reg*8 +: 8];
    assign grp_hit  = |grp_bits;
    assign grp_last = (grp_reg == G_W'(GROUPS - 1));
    always_comb
    begin
        grp_first = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (grp_bits[b])
                grp_first = 3'(b);
        end
    end

    // sequencer: memory control, counter update and result formation
    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        scan_next       = scan_reg;
        grp_next        = grp_reg;
        out_load        = 1'b0;
        status_next     = 1'b0;
        present_next    = 1'b0;
        neighbor_next   = '0;
        count_out_next  = edge_total_reg;
        mem_re          = 1'b0;
        mem_raddr       = A_W'(from_vertex);
        mem_we          = 1'b0;
        mem_waddr       = from_addr;
        mem_wdata       = row_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mem_re     = !bad_now;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    if (bad_reg)
                    begin
                        status_next = 1'b1;
                        out_load    = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        case (cmd_reg)
                            abm_pkg::CMD_INSERT,
                            abm_pkg::CMD_REMOVE:
                            begin
                                if (cmd_reg == abm_pkg::CMD_INSERT)
                                begin
                                    if (!cur_bit && (edge_total_reg < abm_pkg::EDGE_TOTAL_MAX))
                                        edge_total_next = edge_total_reg + 1'b1;
                                end
                                else if (cur_bit && (edge_total_reg != '0))
                                begin
                                    edge_total_next = edge_total_reg - 1'b1;
                                end
                                mem_we             = 1'b1;
                                mem_waddr          = from_addr;
                                mem_wdata[to_addr] = (cmd_reg == abm_pkg::CMD_INSERT);
                                if (need_mirror)
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = to_addr;
                                    state_next = ST_MIRROR;
                                end
                                else
                                begin
                                    count_out_next = edge_total_next;
                                    out_load       = 1'b1;
                                    state_next     = ST_IDLE;
                                end
                            end
                            abm_pkg::CMD_QUERY:
                            begin
                                present_next = cur_bit;
                                out_load     = 1'b1;
                                state_next   = ST_IDLE;
                            end
                            default:
                            begin
                                if (start_ok)
                                begin
                                    scan_next  = PAD_W'(row_data) & search_mask;
                                    grp_next   = G_W'(start_reg >> 3);
                                    state_next = ST_SCAN;
                                end
                                else
                                begin
                                    neighbor_next = abm_pkg::VCOUNT_W'(n_eff);
                                    out_load      = 1'b1;
                                    state_next    = ST_IDLE;
                                end
                            end
                        endcase
                    end
                end
            end

            ST_MIRROR:
            begin
                if (out_free)
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = to_addr;
                    mem_wdata[from_addr] = (cmd_reg == abm_pkg::CMD_INSERT);
                    out_load             = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (grp_hit || grp_last)
                begin
                    if (out_free)
                    begin
                        if (grp_hit)
                            neighbor_next = abm_pkg::VCOUNT_W'({grp_reg, grp_first});
                        else
                            neighbor_next = abm_pkg::VCOUNT_W'(n_eff);
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // row memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_valid_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            edge_total_reg   <= '0;
            out_valid_reg    <= 1'b0;
            vertex_count_reg <= abm_pkg::VERTEX_COUNT_RESET;
            directed_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            out_valid_reg  <= out_valid_next;
            if (mem_re)
                rd_valid_reg <= row_valid_reg[mem_raddr];
            if (mem_we)
                row_valid_reg[mem_waddr] <= 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    abm_pkg::REG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                    abm_pkg::REG_DIRECTED:     directed_reg     <= cfg_data[0];
                    default:                   directed_reg     <= directed_reg;
                endcase
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= command;
            from_reg  <= from_vertex;
            to_reg    <= to_vertex;
            start_reg <= search_start;
            bad_reg   <= bad_now;
        end
        scan_reg <= scan_next;
        grp_reg  <= grp_next;
        if (out_load)
        begin
            status_reg    <= status_next;
            present_reg   <= present_next;
            neighbor_reg  <= neighbor_next;
            count_out_reg <= count_out_next;
        end
    end

endmodule

[sv/abm_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the adjacency bit matrix unit, bound to the top level
module abm_checker #(
    parameter int MAX_VERTICES = abm_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          status,
    input  logic                          edge_present,
    input  logic [abm_pkg::VCOUNT_W-1:0]  neighbor,
    input  logic [abm_pkg::COUNT_W-1:0]   edge_count
);

    logic                          seen_reg;
    logic [abm_pkg::COUNT_W-1:0]   last_count_reg;
    logic                          out_beat;
    logic                          count_step_ok;

    assign out_beat      = out_valid && !out_stall;
    assign count_step_ok = ((edge_count - last_count_reg) <= abm_pkg::COUNT_W'(1)) ||
                           ((last_count_reg - edge_count) <= abm_pkg::COUNT_W'(1));

    // edge count of the last delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_count_reg <= '0;
        end
        else if (out_beat)
        begin
            seen_reg       <= 1'b1;
            last_count_reg <= edge_count;
        end
    end

    // a failed command reports no edge and no neighbor
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !edge_present && (neighbor == '0))
        else $error("failed command carries edge or neighbor data");

    // a present edge comes only from a successful query
    a_present_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && edge_present |-> !status && (neighbor == '0))
        else $error("edge_present set on a non-query result");

    // a neighbor never exceeds the built maximum
    a_neighbor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(neighbor) <= 32'(MAX_VERTICES)))
        else $error("neighbor beyond vertex range");

    // one command moves the edge count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && seen_reg |-> count_step_ok)
        else $error("edge count jumped by more than one");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({status, edge_present, neighbor, edge_count}))
        else $error("stalled result changed");

endmodule

bind adjacency_bit_matrix_unit abm_checker #(
    .MAX_VERTICES(MAX_VERTICES)
) u_abm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .edge_present (edge_present),
    .neighbor     (neighbor),
    .edge_count   (edge_count)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for the adjacency bit matrix unit with its own graph model
module tb_top;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int NV           = abm_pkg::DEFAULT_MAX_VERTICES;

    // one reply beat as the block returns it
    typedef struct packed {
        logic                         status;
        logic                         present;
        logic [abm_pkg::VCOUNT_W-1:0] nbr;
        logic [abm_pkg::COUNT_W-1:0]  count;
    } graph_reply_t;

    // a command beat with the reply it should produce
    typedef struct packed {
        logic [abm_pkg::CMD_W-1:0]    cmd;
        logic [abm_pkg::VERTEX_W-1:0] src;
        logic [abm_pkg::VERTEX_W-1:0] dst;
        logic [abm_pkg::VERTEX_W-1:0] start;
        graph_reply_t                 reply;
    } awaited_reply_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [abm_pkg::CMD_W-1:0]     command      = abm_pkg::CMD_QUERY;
    logic [abm_pkg::VERTEX_W-1:0]  from_vertex  = '0;
    logic [abm_pkg::VERTEX_W-1:0]  to_vertex    = '0;
    logic [abm_pkg::VERTEX_W-1:0]  search_start = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic                          status;
    logic                          edge_present;
    logic [abm_pkg::VCOUNT_W-1:0]  neighbor;
    logic [abm_pkg::COUNT_W-1:0]   edge_count;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [abm_pkg::CFG_IDX_W-1:0] cfg_index    = abm_pkg::REG_VERTEX_COUNT;
    logic [abm_pkg::VCOUNT_W-1:0]  cfg_data     = '0;

    // graph model state and its copy of the registers
    logic [NV-1:0]                 adj_rows [NV];
    logic [abm_pkg::COUNT_W-1:0]   edge_total_model;
    logic [abm_pkg::VCOUNT_W-1:0]  vcount_cfg;
    logic                          directed_cfg;

    awaited_reply_t       awaited[$];
    int                   send_idle_pct   = 0;
    int                   recv_idle_pct   = 0;
    int                   stall_hold_left = 0;
    int                   mismatch_count  = 0;
    int                   cmds_accepted   = 0;
    int                   replies_checked = 0;
    int                   reg_writes      = 0;
    int                   cycle_count;

    adjacency_bit_matrix_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .from_vertex  (from_vertex),
        .to_vertex    (to_vertex),
        .search_start (search_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .edge_present (edge_present),
        .neighbor     (neighbor),
        .edge_count   (edge_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // apply one command to the graph model and return its reply
    function automatic graph_reply_t apply_graph_command(
        input logic [abm_pkg::CMD_W-1:0] cmd, input logic [abm_pkg::VERTEX_W-1:0] v,
        input logic [abm_pkg::VERTEX_W-1:0] w, input logic [abm_pkg::VERTEX_W-1:0] s);
        graph_reply_t r;
        int           n;
        bit           found;
        r     = '0;
        found = 1'b0;
        n     = (vcount_cfg > NV) ? NV : int'(vcount_cfg);
        if (v >= n || (cmd != abm_pkg::CMD_NEXT && w >= n))
            r.status = 1'b1;
        else
        begin
            case (cmd)
                abm_pkg::CMD_INSERT:
                begin
                    if (!adj_rows[v][w] && edge_total_model != abm_pkg::EDGE_TOTAL_MAX)
                        edge_total_model = edge_total_model + 1'b1;
                    adj_rows[v][w] = 1'b1;
                    if (!directed_cfg)
                        adj_rows[w][v] = 1'b1;
                end
                abm_pkg::CMD_REMOVE:
                begin
                    if (adj_rows[v][w] && edge_total_model != '0)
                        edge_total_model = edge_total_model - 1'b1;
                    adj_rows[v][w] = 1'b0;
                    if (!directed_cfg)
                        adj_rows[w][v] = 1'b0;
                end
                abm_pkg::CMD_QUERY:
                    r.present = adj_rows[v][w];
                default:
                begin
                    // first set column at or after the start, else the vertex count
                    r.nbr = abm_pkg::VCOUNT_W'(n);
                    for (int c = int'(s); c < n; c++)
                    begin
                        if (!found && adj_rows[v][c])
                        begin
                            r.nbr = abm_pkg::VCOUNT_W'(c);
                            found = 1'b1;
                        end
                    end
                end
            endcase
        end
        r.count = edge_total_model;
        return r;
    endfunction

    // vertex index biased toward a small hot set and the range boundary
    function automatic logic [abm_pkg::VERTEX_W-1:0] pick_vertex(input int n);
        int roll;
        roll = $urandom_range(99);
        if (n == 0 || roll < 15)
            return abm_pkg::VERTEX_W'($urandom_range(NV - 1));
        if (roll < 25)
            return abm_pkg::VERTEX_W'(n - 1);
        return abm_pkg::VERTEX_W'($urandom_range((n < 8 ? n : 8) - 1));
    endfunction

    // record each accepted command beat with its expected reply
    always @(posedge clk)
    begin : cmd_monitor
        awaited_reply_t item;
        if (rst_n && in_valid && !in_stall)
        begin
            item.cmd   = command;
            item.src   = from_vertex;
            item.dst   = to_vertex;
            item.start = search_start;
            item.reply = apply_graph_command(command, from_vertex, to_vertex, search_start);
            awaited    = {awaited, item};
            cmds_accepted++;
        end
    end

    // result receiver: random stalls or a long hold-off on request
    always @(posedge clk)
    begin
        if (stall_hold_left > 0)
        begin
            stall_hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // compare each reply beat with the oldest expectation
    always @(posedge clk)
    begin : reply_check
        awaited_reply_t exp_item;
        if (rst_n && out_valid && !out_stall)
        begin
            replies_checked++;
            if (awaited.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: reply with nothing outstanding: %s %0b %0d %0d %0d",
                             $realtime, "status/present/nbr/count", status, edge_present,
                             neighbor, edge_count);
                mismatch_count++;
            end
            else
            begin
                exp_item = awaited.pop_front();
                if (status !== exp_item.reply.status ||
                    edge_present !== exp_item.reply.present ||
                    neighbor !== exp_item.reply.nbr || edge_count !== exp_item.reply.count)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("%0t: cmd %0d src %0d dst %0d start %0d", $realtime,
                                 exp_item.cmd, exp_item.src, exp_item.dst, exp_item.start);
                        $display("    expected status %0b present %0b nbr %0d count %0d",
                                 exp_item.reply.status, exp_item.reply.present,
                                 exp_item.reply.nbr, exp_item.reply.count);
                        $display("    actual   status %0b present %0b nbr %0d count %0d",
                                 status, edge_present, neighbor, edge_count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // send one command beat, with random idle cycles ahead of it
    task automatic send_cmd(input logic [abm_pkg::CMD_W-1:0] cmd,
                            input logic [abm_pkg::VERTEX_W-1:0] v,
                            input logic [abm_pkg::VERTEX_W-1:0] w,
                            input logic [abm_pkg::VERTEX_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        from_vertex  <= v;
        to_vertex    <= w;
        search_start <= s;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait until every reply is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write both registers while the block is idle
    task automatic configure(input logic [abm_pkg::VCOUNT_W-1:0] vcount, input logic dir);
        logic [abm_pkg::VCOUNT_W-1:0] dir_word;
        wait_idle();
        dir_word    = abm_pkg::VCOUNT_W'($urandom_range(127));
        dir_word[0] = dir;
        cfg_valid <= 1'b1;
        cfg_index <= abm_pkg::REG_VERTEX_COUNT;
        cfg_data  <= vcount;
        do
            @(posedge clk);
        while (!cfg_ready);
        vcount_cfg = vcount;
        cfg_index <= abm_pkg::REG_DIRECTED;
        cfg_data  <= dir_word;
        do
            @(posedge clk);
        while (!cfg_ready);
        directed_cfg = dir;
        cfg_valid <= 1'b0;
        reg_writes += 2;
    endtask

    // reset defaults: undirected, all 64 vertices, every command kind
    task automatic test_basic_commands();
        send_cmd(abm_pkg::CMD_INSERT, 6'd0, 6'd63, 6'd0);
        send_cmd(abm_pkg::CMD_QUERY, 6'd63, 6'd0, 6'd0);
        send_cmd(abm_pkg::CMD_QUERY, 6'd5, 6'd5, 6'd0);
        send_cmd(abm_pkg::CMD_NEXT, 6'd63, 6'd17, 6'd0);
        send_cmd(abm_pkg::CMD_NEXT, 6'd0, 6'd0, 6'd63);
        send_cmd(abm_pkg::CMD_INSERT, 6'd63, 6'd63, 6'd0);
        send_cmd(abm_pkg::CMD_NEXT, 6'd63, 6'd0, 6'd1);
        send_cmd(abm_pkg::CMD_INSERT, 6'd0, 6'd63, 6'd0);
        send_cmd(abm_pkg::CMD_REMOVE, 6'd21, 6'd42, 6'd0);
    endtask

    // mirror bit left set after a directed remove, count already at zero
    task automatic test_count_underflow();
        configure(7'd64, 1'b1);
        send_cmd(abm_pkg::CMD_REMOVE, 6'd0, 6'd63, 6'd0);
        send_cmd(abm_pkg::CMD_REMOVE, 6'd63, 6'd63, 6'd0);
        send_cmd(abm_pkg::CMD_REMOVE, 6'd63, 6'd0, 6'd0);
    endtask

    // vertices at the count boundary, zero count, count above the maximum
    task automatic test_vertex_limits();
        configure(7'd10, 1'b0);
        send_cmd(abm_pkg::CMD_INSERT, 6'd10, 6'd0, 6'd0);
        send_cmd(abm_pkg::CMD_QUERY, 6'd0, 6'd10, 6'd0);
        send_cmd(abm_pkg::CMD_INSERT, 6'd9, 6'd9, 6'd0);
        send_cmd(abm_pkg::CMD_NEXT, 6'd9, 6'd63, 6'd10);
        send_cmd(abm_pkg::CMD_NEXT, 6'd10, 6'd0, 6'd0);
        send_cmd(abm_pkg::CMD_NEXT, 6'd9, 6'd0, 6'd0);
        configure(7'd0, 1'b1);
        send_cmd(abm_pkg::CMD_INSERT, 6'd0, 6'd0, 6'd0);
        send_cmd(abm_pkg::CMD_NEXT, 6'd0, 6'd0, 6'd0);
        configure(7'd127, 1'b0);
        send_cmd(abm_pkg::CMD_QUERY, 6'd63, 6'd63, 6'd0);
        send_cmd(abm_pkg::CMD_INSERT, 6'd63, 6'd62, 6'd0);
        send_cmd(abm_pkg::CMD_NEXT, 6'd62, 6'd0, 6'd0);
    endtask

    // edge kept beyond a shrunk vertex count, reachable again after growth
    task automatic test_shrunk_range();
        configure(7'd64, 1'b1);
        send_cmd(abm_pkg::CMD_INSERT, 6'd40, 6'd50, 6'd0);
        configure(7'd45, 1'b1);
        send_cmd(abm_pkg::CMD_QUERY, 6'd40, 6'd50, 6'd0);
        send_cmd(abm_pkg::CMD_NEXT, 6'd40, 6'd0, 6'd0);
        configure(7'd64, 1'b1);
        send_cmd(abm_pkg::CMD_QUERY, 6'd40, 6'd50, 6'd0);
    endtask

    // random commands, reconfigured every fifty beats
    task automatic test_random_traffic(input int items, input int snd_pct, input int rcv_pct);
        logic [abm_pkg::VCOUNT_W-1:0] vc;
        int                           n;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int k = 0; k < items; k++)
        begin
            if (k % 50 == 0)
            begin
                case ($urandom_range(7))
                    0:       vc = 7'd0;
                    1:       vc = 7'd1;
                    2:       vc = 7'd2;
                    3:       vc = 7'd127;
                    4:       vc = abm_pkg::VCOUNT_W'($urandom_range(126, 65));
                    5:       vc = abm_pkg::VCOUNT_W'($urandom_range(63, 3));
                    default: vc = 7'd64;
                endcase
                configure(vc, 1'($urandom_range(1)));
            end
            n = (vcount_cfg > NV) ? NV : int'(vcount_cfg);
            send_cmd(abm_pkg::CMD_W'($urandom_range(3)), pick_vertex(n), pick_vertex(n),
                     pick_vertex(n));
        end
    endtask

    // receiver holds off while commands keep coming, so the block backs up
    task automatic test_backpressure();
        configure(7'd64, 1'b0);
        send_idle_pct   = 0;
        recv_idle_pct   = 10;
        stall_hold_left = 300;
        for (int k = 0; k < 24; k++)
            send_cmd(abm_pkg::CMD_W'($urandom_range(3)), pick_vertex(NV), pick_vertex(NV),
                     pick_vertex(NV));
    endtask

    // watchdog
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // test sequence
    initial
    begin
        for (int r = 0; r < NV; r++)
            adj_rows[r] = '0;
        edge_total_model = '0;
        vcount_cfg       = abm_pkg::VERTEX_COUNT_RESET;
        directed_cfg     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_commands();
        test_count_underflow();
        test_vertex_limits();
        test_shrunk_range();
        test_random_traffic(135, 27, 88);
        test_random_traffic(135, 88, 27);
        test_random_traffic(135, 0, 0);
        test_backpressure();
        wait_idle();

        $display("covered %0d commands and %0d replies across %0d register writes,",
                 cmds_accepted, replies_checked, reg_writes);
        $display("both modes, out-of-range vertices, count underflow and a long receiver hold");
        if (mismatch_count == 0 && awaited.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
